// ===== hw/rtl/mxt_pkg.sv =====
// Shared constants and types for the maximum-XOR binary trie unit.
package mxt_pkg;

  localparam int KEY_BITS   = 42;
  localparam int POOL_NODES = 4096;

  localparam int NODE_W  = $clog2(POOL_NODES);
  localparam int CNT_W   = NODE_W + 1;
  localparam int LINK_W  = 2 * NODE_W;
  localparam int LEVEL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  localparam logic [CNT_W-1:0] FULL_LIMIT = CNT_W'(POOL_NODES - KEY_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_RESP
  } state_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_QUERY  = 1'b1
  } mode_t;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] best;
    logic                full;
  } result_t;

endpackage

// ===== hw/rtl/max_xor_binary_trie_unit.sv =====
// Top level of the maximum-XOR binary trie unit: request handshake and result register.
//
// Each request either inserts a key into the trie or asks for the largest XOR of
// the key with any stored key. A request is taken when start is high and busy is
// low; its single result appears on best_xor and pool_full, marked by done, which
// is high for exactly one cycle, and the receiver has no way to hold it off. The
// walk reads at most one node link per trie level from the link memory; a query
// ends early where its path runs out, and an insert that is rejected for lack of
// free nodes skips the walk. A new request may be taken in the cycle that done is
// shown.
module max_xor_binary_trie_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [mxt_pkg::KEY_BITS-1:0] key,
  output logic                         done,
  output logic [mxt_pkg::KEY_BITS-1:0] best_xor,
  output logic                         pool_full
);
  import mxt_pkg::*;

  logic    idle;
  logic    accept;
  result_t res;

  assign accept = start && !busy;
  assign busy   = !idle;

  mxt_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .mode  (mode),
    .key   (key),
    .idle  (idle),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
    if (res.valid) begin
      best_xor  <= res.best;
      pool_full <= res.full;
    end
  end

endmodule

// ===== hw/rtl/mxt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mxt_walker.sv =====
// Trie walk sequencer: reads one node link per level, allocates and links new nodes.
module mxt_walker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         mode,
  input  logic [mxt_pkg::KEY_BITS-1:0] key,
  output logic                         idle,
  output mxt_pkg::result_t             res
);
  import mxt_pkg::*;

  state_t              state, state_next;
  logic [LEVEL_W-1:0]  level, level_next;
  logic [NODE_W-1:0]   node, node_next;
  logic [KEY_BITS-1:0] key_q, key_q_next;
  logic                mode_q, mode_q_next;
  logic [KEY_BITS-1:0] best, best_next;
  logic                full, full_next;
  logic [CNT_W-1:0]    nodes_used, nodes_used_next;
  logic                root_valid, root_valid_next;

  logic                we;
  logic [NODE_W-1:0]   waddr;
  logic [LINK_W-1:0]   wdata;
  logic [NODE_W-1:0]   raddr;
  logic [LINK_W-1:0]   rdata;

  logic [LINK_W-1:0]   link;
  logic [LINK_W-1:0]   base;
  logic [NODE_W-1:0]   c0, c1, nxt, want_child, other_child, new_idx;
  logic                kbit;

  mxt_ram #(
    .WIDTH(LINK_W),
    .DEPTH(POOL_NODES)
  ) u_links (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      nodes_used <= CNT_W'(1);
      root_valid <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      root_valid <= root_valid_next;
    end
    level  <= level_next;
    node   <= node_next;
    key_q  <= key_q_next;
    mode_q <= mode_q_next;
    best   <= best_next;
    full   <= full_next;
  end

  // The root link reads as empty until the first write to it.
  assign link    = (node == '0 && !root_valid) ? '0 : rdata;
  assign c0      = link[NODE_W-1:0];
  assign c1      = link[LINK_W-1:NODE_W];
  assign kbit    = key_q[level];
  assign new_idx = nodes_used[NODE_W-1:0];
  assign base    = (state == ST_ALLOC) ? '0 : link;

  always_comb begin
    state_next      = state;
    level_next      = level;
    node_next       = node;
    key_q_next      = key_q;
    mode_q_next     = mode_q;
    best_next       = best;
    full_next       = full;
    nodes_used_next = nodes_used;
    root_valid_next = root_valid;
    we              = 1'b0;
    waddr           = node;
    wdata           = kbit ? {new_idx, base[NODE_W-1:0]} : {base[LINK_W-1:NODE_W], new_idx};
    raddr           = '0;
    nxt             = kbit ? c1 : c0;
    want_child      = kbit ? c0 : c1;
    other_child     = kbit ? c1 : c0;
    res.valid       = 1'b0;
    res.best        = best;
    res.full        = full;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          mode_q_next = mode;
          key_q_next  = key;
          best_next   = '0;
          full_next   = 1'b0;
          level_next  = LEVEL_W'(KEY_BITS - 1);
          node_next   = '0;
          if (mode == MODE_INSERT && nodes_used > FULL_LIMIT) begin
            full_next  = 1'b1;
            state_next = ST_RESP;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (mode_q == MODE_INSERT) begin
          if (nxt == '0) begin
            we              = 1'b1;
            nodes_used_next = nodes_used + 1'b1;
            if (node == '0) begin
              root_valid_next = 1'b1;
            end
            if (level == '0) begin
              state_next = ST_RESP;
            end else begin
              node_next  = new_idx;
              level_next = level - 1'b1;
              state_next = ST_ALLOC;
            end
          end else if (level == '0) begin
            state_next = ST_RESP;
          end else begin
            raddr      = nxt;
            node_next  = nxt;
            level_next = level - 1'b1;
          end
        end else begin
          if (want_child != '0) begin
            best_next[level] = 1'b1;
            nxt              = want_child;
          end else begin
            nxt = other_child;
          end
          if (nxt == '0 || level == '0) begin
            state_next = ST_RESP;
          end else begin
            raddr      = nxt;
            node_next  = nxt;
            level_next = level - 1'b1;
          end
        end
      end
      ST_ALLOC: begin
        we              = 1'b1;
        nodes_used_next = nodes_used + 1'b1;
        if (level == '0) begin
          state_next = ST_RESP;
        end else begin
          node_next  = new_idx;
          level_next = level - 1'b1;
        end
      end
      ST_RESP: begin
        res.valid  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign idle = (state == ST_IDLE);

endmodule

// ===== test/tb_max_xor_binary_trie_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the maximum-XOR binary trie unit with a trie predictor.
module tb_max_xor_binary_trie_unit;
  import mxt_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_ITEMS    = 250;
  localparam int BASE_COUNT     = 6;
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;

  class trie_scoreboard;
    int child_idx[POOL_NODES][2];
    int nodes_used;
    logic [KEY_BITS-1:0] best_q[$];
    logic full_q[$];
    int errors;

    function new();
      foreach (child_idx[i]) begin
        child_idx[i][0] = 0;
        child_idx[i][1] = 0;
      end
      nodes_used = 1;
      errors = 0;
    endfunction

    function bit pool_exhausted();
      return (POOL_NODES - nodes_used) < KEY_BITS;
    endfunction

    function int pending();
      return best_q.size();
    endfunction

    function bit insert_key(logic [KEY_BITS-1:0] k);
      int node;
      int nxt;
      bit dir;
      node = 0;
      if (pool_exhausted()) return 1'b1;
      for (int b = KEY_BITS - 1; b >= 0; b--) begin
        dir = k[b];
        nxt = child_idx[node][dir];
        if (nxt == 0) begin
          nxt = nodes_used;
          nodes_used++;
          child_idx[nxt][0] = 0;
          child_idx[nxt][1] = 0;
          child_idx[node][dir] = nxt;
        end
        node = nxt;
      end
      return 1'b0;
    endfunction

    function logic [KEY_BITS-1:0] max_xor(logic [KEY_BITS-1:0] k);
      logic [KEY_BITS-1:0] best;
      int node;
      int nxt;
      bit want;
      best = '0;
      node = 0;
      for (int b = KEY_BITS - 1; b >= 0; b--) begin
        want = ~k[b];
        nxt = child_idx[node][want];
        if (nxt != 0) begin
          best[b] = 1'b1;
        end else begin
          nxt = child_idx[node][!want];
          if (nxt == 0) return best;
        end
        node = nxt;
      end
      return best;
    endfunction

    function void note_request(mode_t m, logic [KEY_BITS-1:0] k);
      if (m == MODE_INSERT) begin
        best_q.push_back('0);
        full_q.push_back(insert_key(k));
      end else begin
        best_q.push_back(max_xor(k));
        full_q.push_back(1'b0);
      end
    endfunction

    function void check_result(logic [KEY_BITS-1:0] best, logic full);
      logic [KEY_BITS-1:0] exp_best;
      logic exp_full;
      if (best_q.size() == 0) begin
        $display("%0t: result with no request pending: best_xor=%h pool_full=%b",
                 $time, best, full);
        errors++;
        return;
      end
      exp_best = best_q.pop_front();
      exp_full = full_q.pop_front();
      if (best !== exp_best) begin
        $display("%0t: best_xor mismatch: expected %h, actual %h", $time, exp_best, best);
        errors++;
      end
      if (full !== exp_full) begin
        $display("%0t: pool_full mismatch: expected %b, actual %b", $time, exp_full, full);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic mode = 1'b0;
  logic [KEY_BITS-1:0] key = '0;
  logic busy;
  logic done;
  logic [KEY_BITS-1:0] best_xor;
  logic pool_full;

  trie_scoreboard sb = new();
  logic [KEY_BITS-1:0] stored_keys[$];
  logic [KEY_BITS-1:0] bases[BASE_COUNT];
  bit steady;
  int idle_cycles;

  max_xor_binary_trie_unit u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .key(key),
    .done(done),
    .best_xor(best_xor),
    .pool_full(pool_full)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(best_xor, pool_full);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [KEY_BITS-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_BITS-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    logic [KEY_BITS-1:0] k;
    logic [KEY_BITS-1:0] one_bit;
    int r;
    k = rand_key();
    r = $urandom_range(0, 99);
    one_bit = '0;
    one_bit[$urandom_range(0, KEY_BITS - 1)] = 1'b1;
    if (r < 35) begin
      k = {bases[$urandom_range(0, BASE_COUNT - 1)][KEY_BITS-1:12], k[11:0]};
    end else if (r < 55 && stored_keys.size() > 0) begin
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      if (r >= 45) k = k ^ one_bit;
    end else if (r < 65 && stored_keys.size() > 0) begin
      k = ~stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    end else if (r < 70) begin
      k = (r < 68) ? KEY_ONES : '0;
    end
    return k;
  endfunction

  task automatic issue_request(input mode_t m, input logic [KEY_BITS-1:0] k);
    int gap;
    start <= 1'b1;
    mode <= m;
    key <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(m, k);
    if (m == MODE_INSERT) stored_keys.push_back(k);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      mode <= 1'($urandom_range(0, 1));
      key <= rand_key();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_phase(input int count);
    mode_t m;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      m = ($urandom_range(0, 1) == 1) ? MODE_QUERY : MODE_INSERT;
      issue_request(m, pick_key());
    end
  endtask

  initial begin
    int fill_count;
    foreach (bases[i]) bases[i] = rand_key();
    steady = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_request(MODE_QUERY, '0);
    issue_request(MODE_QUERY, KEY_ONES);
    issue_request(MODE_INSERT, '0);
    issue_request(MODE_QUERY, '0);
    issue_request(MODE_QUERY, KEY_ONES);
    issue_request(MODE_INSERT, KEY_ONES);
    issue_request(MODE_QUERY, '0);
    issue_request(MODE_QUERY, 42'h15555555555);
    issue_request(MODE_INSERT, '0);
    issue_request(MODE_INSERT, 42'h2AAAAAAAAAA);
    issue_request(MODE_QUERY, 42'h15555555555);
    issue_request(MODE_QUERY, 42'h2AAAAAAAAAA);
    issue_request(MODE_INSERT, 42'h20000000000);
    issue_request(MODE_INSERT, 42'h00000000001);
    issue_request(MODE_QUERY, 42'h20000000000);
    issue_request(MODE_QUERY, 42'h1FFFFFFFFFE);
    issue_request(MODE_INSERT, 42'h2AAAAAAAAAA);
    issue_request(MODE_QUERY, 42'h00000000001);

    random_phase(PHASE_ITEMS);

    // Mostly random inserts until the pool cannot take a full path or 200 are sent.
    steady = 1'b0;
    fill_count = 0;
    while (!sb.pool_exhausted() && fill_count < 200) begin
      if ($urandom_range(0, 3) == 0) issue_request(MODE_QUERY, pick_key());
      else issue_request(MODE_INSERT, rand_key());
      fill_count++;
    end
    issue_request(MODE_INSERT, stored_keys[0]);
    issue_request(MODE_INSERT, rand_key());
    issue_request(MODE_QUERY, '0);
    issue_request(MODE_QUERY, KEY_ONES);

    random_phase(PHASE_ITEMS);

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mxt_pkg.sv
hw/rtl/mxt_ram.sv
hw/rtl/mxt_walker.sv
hw/rtl/max_xor_binary_trie_unit.sv
test/tb_max_xor_binary_trie_unit.sv
